@@ sv/ezyz_pkg.sv @@
// Shared constants, types and tables of the z-y-z Euler rotation matrix unit.
`default_nettype none
package ezyz_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_BITS      = 16;
  localparam int TRIG_FRAC     = 30;
  localparam int CORDIC_ITERS  = 30;
  localparam int ITER_BITS     = $clog2(CORDIC_ITERS);
  // CORDIC datapath: 32-bit binary angle, x/y in Q30 with headroom
  localparam int Z_BITS  = 33;
  localparam int XY_BITS = 33;
  localparam int PROD_BITS = 2 * XY_BITS;
  localparam logic signed [XY_BITS-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [OUT_BITS-1:0] OUT_ONE = 16'sd1 <<< OUT_FRAC_BITS;

  typedef logic signed [XY_BITS-1:0] trig_t;
  typedef logic signed [Z_BITS-1:0]  zang_t;
  typedef logic signed [OUT_BITS-1:0] out_t;

  typedef struct packed {
    trig_t x;
    trig_t y;
    zang_t z;
    logic  flip;
  } cordic_lane_t;

  function automatic zang_t atan_entry(input int i);
    case (i)
      0:  atan_entry = 33'sd536870912;
      1:  atan_entry = 33'sd316933406;
      2:  atan_entry = 33'sd167458907;
      3:  atan_entry = 33'sd85004756;
      4:  atan_entry = 33'sd42667331;
      5:  atan_entry = 33'sd21354465;
      6:  atan_entry = 33'sd10679838;
      7:  atan_entry = 33'sd5340245;
      8:  atan_entry = 33'sd2670163;
      9:  atan_entry = 33'sd1335087;
      10: atan_entry = 33'sd667544;
      11: atan_entry = 33'sd333772;
      12: atan_entry = 33'sd166886;
      13: atan_entry = 33'sd83443;
      14: atan_entry = 33'sd41722;
      15: atan_entry = 33'sd20861;
      16: atan_entry = 33'sd10430;
      17: atan_entry = 33'sd5215;
      18: atan_entry = 33'sd2608;
      19: atan_entry = 33'sd1304;
      20: atan_entry = 33'sd652;
      21: atan_entry = 33'sd326;
      22: atan_entry = 33'sd163;
      23: atan_entry = 33'sd81;
      24: atan_entry = 33'sd41;
      25: atan_entry = 33'sd20;
      26: atan_entry = 33'sd10;
      27: atan_entry = 33'sd5;
      28: atan_entry = 33'sd3;
      29: atan_entry = 33'sd1;
      default: atan_entry = '0;
    endcase
  endfunction

  // Q30 product rounded half up back to Q30
  function automatic trig_t qmul(input trig_t a, input trig_t b);
    logic signed [PROD_BITS-1:0] p;
    begin
      p = PROD_BITS'(a) * PROD_BITS'(b) + (PROD_BITS'(1) <<< (TRIG_FRAC - 1));
      qmul = XY_BITS'(p >>> TRIG_FRAC);
    end
  endfunction

  // Q30 to Q1.OUT_FRAC_BITS, round half up, saturate to plus or minus one
  function automatic out_t to_out(input logic signed [XY_BITS+1:0] v);
    logic signed [XY_BITS+1:0] r;
    begin
      r = (v + ((XY_BITS+2)'(1) <<< (TRIG_FRAC - OUT_FRAC_BITS - 1)))
          >>> (TRIG_FRAC - OUT_FRAC_BITS);
      if (r > (XY_BITS+2)'(OUT_ONE))       to_out = OUT_ONE;
      else if (r < -(XY_BITS+2)'(OUT_ONE)) to_out = -OUT_ONE;
      else                                 to_out = OUT_BITS'(r);
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/ezyz_cordic_stage.sv @@
// One registered CORDIC micro-rotation stage for three angle lanes.
`default_nettype none
module ezyz_cordic_stage (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  wire [ezyz_pkg::ITER_BITS-1:0]    iter,
  input  wire                              in_valid,
  input  wire ezyz_pkg::cordic_lane_t      in_lane [3],
  input  wire                              in_body,
  output logic                             out_valid,
  output ezyz_pkg::cordic_lane_t           out_lane [3],
  output logic                             out_body
);

  ezyz_pkg::cordic_lane_t lane_next [3];

  // iter is tied to a constant per stage, so the shifts reduce to wiring
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_next[k].flip = in_lane[k].flip;
      if (!in_lane[k].z[ezyz_pkg::Z_BITS-1]) begin
        lane_next[k].x = in_lane[k].x - (in_lane[k].y >>> iter);
        lane_next[k].y = in_lane[k].y + (in_lane[k].x >>> iter);
        lane_next[k].z = in_lane[k].z - ezyz_pkg::atan_entry(int'(iter));
      end else begin
        lane_next[k].x = in_lane[k].x + (in_lane[k].y >>> iter);
        lane_next[k].y = in_lane[k].y - (in_lane[k].x >>> iter);
        lane_next[k].z = in_lane[k].z + ezyz_pkg::atan_entry(int'(iter));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_lane <= lane_next;
      out_body <= in_body;
    end
  end

endmodule
`default_nettype wire

@@ sv/ezyz_matrix.sv @@
// Matrix product pipeline: pairwise products, triple products, sums and output rounding.
`default_nettype none
module ezyz_matrix (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  in_valid,
  input  wire ezyz_pkg::trig_t sph,
  input  wire ezyz_pkg::trig_t cph,
  input  wire ezyz_pkg::trig_t sth,
  input  wire ezyz_pkg::trig_t cth,
  input  wire ezyz_pkg::trig_t sps,
  input  wire ezyz_pkg::trig_t cps,
  input  wire                  in_body,
  output logic                 out_valid,
  output ezyz_pkg::out_t       m [9]
);

  typedef logic signed [ezyz_pkg::XY_BITS+1:0] sum_t;

  // stage A: first products
  logic v_a, body_a;
  ezyz_pkg::trig_t ss_a, sc_a, cs_a, cc_a, tc_a, ts_a, st_ps, st_cs, st_c, st_s, cth_a;
  ezyz_pkg::trig_t sps_a, cps_a;
  // stage B: second products of triples
  logic v_b, body_b;
  ezyz_pkg::trig_t ss_b, sc_b, cs_b, cc_b, tcc, tcs, tsc, tss;
  ezyz_pkg::trig_t p02, p12, p20, p21, cth_b;
  // stage C: sums and output
  sum_t e [9];
  logic body_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a <= in_valid;
      v_b <= v_a;
      out_valid <= v_b;
    end
    if (en) begin
      ss_a  <= ezyz_pkg::qmul(sps, sph);
      sc_a  <= ezyz_pkg::qmul(sps, cph);
      cs_a  <= ezyz_pkg::qmul(cps, sph);
      cc_a  <= ezyz_pkg::qmul(cps, cph);
      tc_a  <= ezyz_pkg::qmul(cth, cph);
      ts_a  <= ezyz_pkg::qmul(cth, sph);
      st_ps <= ezyz_pkg::qmul(cps, sth);
      st_cs <= ezyz_pkg::qmul(sps, sth);
      st_c  <= ezyz_pkg::qmul(sth, cph);
      st_s  <= ezyz_pkg::qmul(sth, sph);
      cth_a <= cth;
      sps_a <= sps;
      cps_a <= cps;
      body_a <= in_body;

      ss_b <= ss_a; sc_b <= sc_a; cs_b <= cs_a; cc_b <= cc_a;
      tcc <= ezyz_pkg::qmul(tc_a, cps_a);
      tsc <= ezyz_pkg::qmul(ts_a, cps_a);
      tcs <= ezyz_pkg::qmul(tc_a, sps_a);
      tss <= ezyz_pkg::qmul(ts_a, sps_a);
      p02 <= st_ps; p12 <= st_cs; p20 <= st_c; p21 <= st_s;
      cth_b <= cth_a;
      body_b <= body_a;

      e[0] <= -sum_t'(ss_b) + sum_t'(tcc);
      e[1] <=  sum_t'(sc_b) + sum_t'(tsc);
      e[2] <=  sum_t'(p02);
      e[3] <= -sum_t'(cs_b) - sum_t'(tcs);
      e[4] <=  sum_t'(cc_b) - sum_t'(tss);
      e[5] <= -sum_t'(p12);
      e[6] <= -sum_t'(p20);
      e[7] <= -sum_t'(p21);
      e[8] <=  sum_t'(cth_b);
      body_c <= body_b;
    end
  end

  // transpose on the body flag
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        m[r*3+k] = ezyz_pkg::to_out(body_c ? e[k*3+r] : e[r*3+k]);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/euler_zyz_rotation_matrix_unit.sv @@
// Top level of the z-y-z Euler rotation matrix unit.
`default_nettype none
// Streams angle triples (phi, theta, psi) and a body flag in, one request per
// cycle, and gives the nine entries of the z-y-z rotation matrix in signed
// Q1.14, transposed when the body flag is set. The pipeline is one
// quadrant-fold register, thirty CORDIC micro-rotation stages shared by the
// three angles side by side, then three product and sum stages and an output
// register. The whole pipeline advances whenever the output register is free
// or being taken, so throughput is one request a cycle.
module euler_zyz_rotation_matrix_unit (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [47:0]  s_tdata,   // phi_angle, theta_angle, psi_angle
  input  wire          s_tuser,   // rotate_body
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [143:0] m_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);

  localparam int N = ezyz_pkg::CORDIC_ITERS;

  logic en;
  ezyz_pkg::cordic_lane_t lane [N+1][3];
  logic vld [N+1];
  logic body [N+1];
  ezyz_pkg::cordic_lane_t fold [3];
  logic mat_valid;
  ezyz_pkg::out_t mat [9];
  ezyz_pkg::trig_t sn [3];
  ezyz_pkg::trig_t cs [3];

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // fold the second and third quadrants by a half turn
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [31:0] a;
      logic [1:0]  q;
      a = {s_tdata[k*ezyz_pkg::ANGLE_BITS +: ezyz_pkg::ANGLE_BITS],
           (32-ezyz_pkg::ANGLE_BITS)'(0)};
      q = a[31:30];
      fold[k].flip = (q == 2'd1) || (q == 2'd2);
      if (fold[k].flip) a = a + 32'h8000_0000;
      fold[k].z = ezyz_pkg::Z_BITS'($signed(a));
      fold[k].x = ezyz_pkg::CORDIC_X0;
      fold[k].y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
    end
    if (en) begin
      lane[0] <= fold;
      body[0] <= s_tuser;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    ezyz_cordic_stage u_stage (
      .clk(clk), .rst(rst), .en(en), .iter(ezyz_pkg::ITER_BITS'(i)),
      .in_valid(vld[i]), .in_lane(lane[i]), .in_body(body[i]),
      .out_valid(vld[i+1]), .out_lane(lane[i+1]), .out_body(body[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sn[k] = lane[N][k].flip ? -lane[N][k].y : lane[N][k].y;
      cs[k] = lane[N][k].flip ? -lane[N][k].x : lane[N][k].x;
    end
  end

  ezyz_matrix u_matrix (
    .clk(clk), .rst(rst), .en(en), .in_valid(vld[N]),
    .sph(sn[0]), .cph(cs[0]), .sth(sn[1]), .cth(cs[1]), .sps(sn[2]), .cps(cs[2]),
    .in_body(body[N]), .out_valid(mat_valid), .m(mat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= mat_valid;
    end
    if (en) begin
      for (int j = 0; j < 9; j++) begin
        m_tdata[j*ezyz_pkg::OUT_BITS +: ezyz_pkg::OUT_BITS] <= mat[j];
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for the z-y-z Euler rotation matrix unit: directed and random angle triples.
`default_nettype none
module testbench;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [47:0]  s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;

  matrix_t expected_matrices [$];
  int          mismatches;
  int          matrices_seen;
  int          requests_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;

  euler_zyz_rotation_matrix_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Floor shift on 64-bit signed values
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Sine and cosine in Q30 by rotation-mode CORDIC with quadrant fold
  task automatic angle_trig(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, xs, ys;
    longint      arc [30];
    arc = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1};
    a = {ang, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - arc[i];
      end else begin
        x = x + ys; y = y - xs; z = z + arc[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic logic signed [15:0] q30_to_q14(longint v);
    longint r;
    r = (v + (64'sd1 <<< 15)) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  task automatic predict_matrix(input logic [15:0] phi, input logic [15:0] theta,
                                input logic [15:0] psi, input logic body,
                                output matrix_t mat);
    longint sph, cph, sth, cth, sps, cps;
    longint e [3][3];
    angle_trig(phi, sph, cph);
    angle_trig(theta, sth, cth);
    angle_trig(psi, sps, cps);
    e[0][0] = -round_q30(sps, sph) + round_q30(round_q30(cth, cph), cps);
    e[0][1] = round_q30(sps, cph) + round_q30(round_q30(cth, sph), cps);
    e[0][2] = round_q30(cps, sth);
    e[1][0] = -round_q30(cps, sph) - round_q30(round_q30(cth, cph), sps);
    e[1][1] = round_q30(cps, cph) - round_q30(round_q30(cth, sph), sps);
    e[1][2] = -round_q30(sps, sth);
    e[2][0] = -round_q30(sth, cph);
    e[2][1] = -round_q30(sth, sph);
    e[2][2] = cth;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        mat.m[r*3+k] = q30_to_q14(body ? e[k][r] : e[r][k]);
  endtask

  // Offer one request, predict it, and wait for acceptance
  task automatic send_angles(input logic [15:0] phi, input logic [15:0] theta,
                             input logic [15:0] psi, input logic body);
    matrix_t mat;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 48'({$urandom, $urandom});
      s_tuser  <= 1'($urandom);
      @(posedge clk);
    end
    predict_matrix(phi, theta, psi, body, mat);
    s_tvalid <= 1'b1;
    s_tdata  <= {psi, theta, phi};
    s_tuser  <= body;
    do @(posedge clk); while (!s_tready);
    expected_matrices.push_back(mat);
    requests_sent++;
  endtask

  task automatic finish_burst();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] edge_angle();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h4000;
      5: return 16'hc000;
      6: return 16'h3fff;
      default: return 16'hbfff;
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] corners [8];
    corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000, 16'hc000,
                16'h3fff, 16'h0001};
    for (int i = 0; i < 8; i++)
      send_angles(corners[i], corners[(i+3)%8], corners[(i+5)%8], 1'b0);
    for (int i = 0; i < 8; i++)
      send_angles(corners[(i+1)%8], corners[i], corners[(i+6)%8], 1'b1);
    send_angles(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_angles(16'h2000, 16'h6000, 16'ha000, 1'b0);
    send_angles(16'h2000, 16'h6000, 16'ha000, 1'b1);
    finish_burst();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0)
        send_angles(edge_angle(), 16'($urandom), edge_angle(), 1'($urandom));
      else
        send_angles(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end
    finish_burst();
  endtask

  // Receiver holds off while the sender keeps offering, so the pipeline fills
  task automatic test_backpressure();
    hold_cycles = 120;
    test_random(150);
  endtask

  // Drive the receive side: random stalls, or a counted hold-off when asked
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each delivered matrix with the oldest prediction
  initial begin
    matrix_t exp_mat;
    logic signed [15:0] got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        matrices_seen++;
        if (expected_matrices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected matrix %h", m_tdata);
        end else begin
          exp_mat = expected_matrices.pop_front();
          for (int k = 0; k < 9; k++) begin
            got = m_tdata[k*16 +: 16];
            if (got !== exp_mat.m[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("matrix %0d entry %0d: expected %0d got %0d",
                         matrices_seen, k, exp_mat.m[k], got);
            end
          end
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("timeout with %0d matrices outstanding", expected_matrices.size());
    $display("FAIL euler_zyz_rotation_matrix_unit");
    $finish;
  end

  initial begin
    int spins;
    mismatches    = 0;
    matrices_seen = 0;
    requests_sent = 0;
    hold_cycles   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 6;
    recv_idle_pct = 6;
    test_directed();
    test_random(800);
    // Stretch with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    send_idle_pct = 6;
    recv_idle_pct = 6;
    test_backpressure();
    test_random(580);
    spins = 0;
    while (expected_matrices.size() != 0 && spins < 10000) begin
      @(posedge clk);
      spins++;
    end
    repeat (40) @(posedge clk);
    $display("Sent %0d angle triples (corners, both body settings, random); checked %0d matrices.",
             requests_sent, matrices_seen);
    if (mismatches == 0 && expected_matrices.size() == 0) begin
      $display("PASS euler_zyz_rotation_matrix_unit");
    end else begin
      $display("%0d mismatches, %0d matrices missing", mismatches, expected_matrices.size());
      $display("FAIL euler_zyz_rotation_matrix_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ euler_zyz_rotation_matrix_unit.f @@
sv/ezyz_pkg.sv
sv/ezyz_cordic_stage.sv
sv/ezyz_matrix.sv
sv/euler_zyz_rotation_matrix_unit.sv
tb/sv/testbench.sv
